[hdl/assert_macros.svh]
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define RTGC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`define RTGC_ASSERT_NEVER(label, cond, msg) \
	`RTGC_ASSERT(label, !(cond), msg)

`endif

[hdl/rtgc_pkg.sv]
`default_nettype none

package rtgc_pkg;

	localparam int QDW = 18;
	localparam int TSW = 9;
	localparam int GDW = 7;
	localparam int CRDW = 16;
	localparam int SZW = 12;
	localparam int CFGW = 16;
	localparam int CFG_IDXW = 3;

	localparam logic [TSW-1:0] TILE_SIZE_RST = TSW'(8);
	localparam logic [GDW-1:0] GRID_COLUMNS_RST = GDW'(64);
	localparam logic [GDW-1:0] GRID_ROWS_RST = GDW'(64);

	typedef enum logic [1:0] {
		OP_WRITE_CELL  = 2'd0,
		OP_FILL_REGION = 2'd1,
		OP_QUERY_RECT  = 2'd2,
		OP_READ_CELL   = 2'd3
	} op_t;

	typedef enum logic [CFG_IDXW-1:0] {
		CFG_TILE_SIZE    = 3'd0,
		CFG_GRID_COLUMNS = 3'd1,
		CFG_GRID_ROWS    = 3'd2,
		CFG_ORIGIN_X     = 3'd3,
		CFG_ORIGIN_Y     = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		op_t                    op;
		logic signed [CRDW-1:0] x_pos;
		logic signed [CRDW-1:0] y_pos;
		logic [SZW-1:0]         width;
		logic [SZW-1:0]         height;
		logic                   cell_value;
	} in_item_t;

	typedef struct packed {
		logic hit;
		logic bad_access;
	} out_item_t;

	typedef struct packed {
		logic                  start;
		logic                  ceil_mode;
		logic signed [QDW-1:0] dividend;
		logic [TSW-1:0]        divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic signed [QDW-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

[hdl/rtgc_ram.sv]
`default_nettype none

module rtgc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hdl/rtgc_div.sv]
`default_nettype none

// Signed floor/ceil divide by a positive divisor, one quotient bit per cycle.
module rtgc_div import rtgc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CW = $clog2(QDW + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic [TSW-1:0]        rem_q;
	logic [TSW-1:0]        dvs_q;
	logic [QDW-1:0]        quo_q;
	logic                  neg_q;
	logic                  ceil_q;
	logic signed [QDW-1:0] res_q;

	logic [TSW:0]   trial;
	logic [TSW:0]   diff;
	logic           fit;
	logic           rnd;
	logic [QDW-1:0] mag;

	always_comb begin
		trial = {rem_q, quo_q[QDW-1]};
		diff  = trial - {1'b0, dvs_q};
		fit   = (trial >= {1'b0, dvs_q});
		// round magnitude up when the remainder is nonzero and the
		// rounding direction points away from zero
		rnd   = (rem_q != '0) && (neg_q != ceil_q);
		mag   = quo_q + QDW'(rnd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
			neg_q  <= 1'b0;
			ceil_q <= 1'b0;
			res_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(QDW);
			rem_q  <= '0;
			dvs_q  <= req.divisor;
			quo_q  <= req.dividend[QDW-1] ? QDW'(-req.dividend) : QDW'(req.dividend);
			neg_q  <= req.dividend[QDW-1];
			ceil_q <= req.ceil_mode;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				rem_q <= fit ? diff[TSW-1:0] : trial[TSW-1:0];
				quo_q <= {quo_q[QDW-2:0], fit};
				cnt_q <= cnt_q - CW'(1);
			end else begin
				res_q  <= neg_q ? $signed(-mag) : $signed(mag);
				done_q <= 1'b1;
				busy_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = res_q;

endmodule

`default_nettype wire

[hdl/rect_vs_tile_grid_collision.sv]
// From accept to result a cell write or read passes SETUP, SCAN, DRAIN and DONE; a refused one goes SETUP to DONE;
// a fill scans the rows it covers between SETUP and DRAIN, and a query waits in DIV before its scan.
// One transaction at a time: the next is accepted the cycle after the result is registered.
// The row walk reads one map word per cycle; a query first runs the 18-step tile divider.
// Reset restores the register defaults and marks every map row clear at once.
`default_nettype none

module rect_vs_tile_grid_collision import rtgc_pkg::*; #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output out_item_t           out_data,
	input  logic                cfg_we,
	input  logic [CFG_IDXW-1:0] cfg_index,
	input  logic [CFGW-1:0]     cfg_data
);

	localparam int CNTW = $clog2(MAX_COLUMNS + 1);
	localparam int RCNTW = $clog2(MAX_ROWS + 1);
	localparam int CIW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int LIMW = 9;
	localparam int NLANE = 4;
	localparam int LANE_LEFT = 0;
	localparam int LANE_RIGHT = 1;
	localparam int LANE_TOP = 2;
	localparam int LANE_BOTTOM = 3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	function automatic logic [LIMW-1:0] clamp_lim(input logic signed [QDW-1:0] v,
		input logic [LIMW-1:0] lim);
		logic [LIMW-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({{(QDW-LIMW){1'b0}}, lim})) begin
			r = lim;
		end else begin
			r = v[LIMW-1:0];
		end
		return r;
	endfunction

	state_t state_q;

	logic [TSW-1:0]         tile_size_q;
	logic [GDW-1:0]         grid_columns_q;
	logic [GDW-1:0]         grid_rows_q;
	logic signed [CRDW-1:0] origin_x_q;
	logic signed [CRDW-1:0] origin_y_q;

	in_item_t item_q;

	logic [CNTW-1:0]  lo_q;
	logic [CNTW-1:0]  hi_q;
	logic [RCNTW-1:0] cy_q;
	logic [RCNTW-1:0] yend_q;
	logic [MAX_ROWS-1:0] row_vld_q;
	logic res_hit_q;
	logic res_bad_q;
	logic out_valid_q;
	out_item_t out_q;

	logic           rd_vld_s1;
	logic [RAW-1:0] row_s1;
	logic           rok_s1;

	logic [LIMW-1:0]  eff_cols9;
	logic [LIMW-1:0]  eff_rows9;
	logic [TSW-1:0]   tile_div;
	logic             is_query;
	logic             wr_mode;
	logic             cell_bad;
	logic [CNTW-1:0]  cell_col;
	logic [RCNTW-1:0] cell_row;
	logic [RCNTW-1:0] cy_nxt;
	logic             last_row;

	logic signed [QDW-1:0] x_ext;
	logic signed [QDW-1:0] y_ext;
	logic signed [QDW-1:0] ox_ext;
	logic signed [QDW-1:0] oy_ext;
	logic signed [QDW-1:0] w_ext;
	logic signed [QDW-1:0] h_ext;
	logic signed [QDW-1:0] src_lo;
	logic signed [QDW-1:0] src_hi;
	logic signed [QDW-1:0] src_top;
	logic signed [QDW-1:0] src_bot;
	logic [LIMW-1:0] col_lo_c;
	logic [LIMW-1:0] col_hi_c;
	logic [LIMW-1:0] row_lo_c;
	logic [LIMW-1:0] row_hi_c;

	div_req_t dreq [NLANE];
	div_rsp_t drsp [NLANE];
	logic     div_start;
	logic     div_done;

	logic [MAX_COLUMNS-1:0] mask_c;
	logic [MAX_COLUMNS-1:0] row_data_c;
	logic                   rd_en;
	logic [RAW-1:0]         rd_addr;
	logic [MAX_COLUMNS-1:0] rd_data;
	logic                   wr_en;
	logic [MAX_COLUMNS-1:0] wr_data;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		eff_cols9 = ({2'b0, grid_columns_q} < LIMW'(MAX_COLUMNS)) ?
			{2'b0, grid_columns_q} : LIMW'(MAX_COLUMNS);
		eff_rows9 = ({2'b0, grid_rows_q} < LIMW'(MAX_ROWS)) ?
			{2'b0, grid_rows_q} : LIMW'(MAX_ROWS);
		tile_div  = (tile_size_q == '0) ? TSW'(1) : tile_size_q;
		is_query  = (item_q.op == OP_QUERY_RECT);
		wr_mode   = (item_q.op == OP_WRITE_CELL) || (item_q.op == OP_FILL_REGION);

		x_ext  = {{(QDW-CRDW){item_q.x_pos[CRDW-1]}}, item_q.x_pos};
		y_ext  = {{(QDW-CRDW){item_q.y_pos[CRDW-1]}}, item_q.y_pos};
		ox_ext = {{(QDW-CRDW){origin_x_q[CRDW-1]}}, origin_x_q};
		oy_ext = {{(QDW-CRDW){origin_y_q[CRDW-1]}}, origin_y_q};
		w_ext  = {{(QDW-SZW){1'b0}}, item_q.width};
		h_ext  = {{(QDW-SZW){1'b0}}, item_q.height};

		cell_bad = item_q.x_pos[CRDW-1] || item_q.y_pos[CRDW-1] ||
			($unsigned(item_q.x_pos) >= CRDW'(eff_cols9)) ||
			($unsigned(item_q.y_pos) >= CRDW'(eff_rows9));
		cell_col = CNTW'(item_q.x_pos[CIW-1:0]);
		cell_row = RCNTW'(item_q.y_pos[RAW-1:0]);

		src_lo  = is_query ? drsp[LANE_LEFT].quotient : x_ext;
		src_hi  = is_query ? drsp[LANE_RIGHT].quotient : x_ext + w_ext;
		src_top = is_query ? drsp[LANE_TOP].quotient : y_ext;
		src_bot = is_query ? drsp[LANE_BOTTOM].quotient : y_ext + h_ext;
		col_lo_c = clamp_lim(src_lo, eff_cols9);
		col_hi_c = clamp_lim(src_hi, eff_cols9);
		row_lo_c = clamp_lim(src_top, eff_rows9);
		row_hi_c = clamp_lim(src_bot, eff_rows9);

		cy_nxt   = cy_q + RCNTW'(1);
		last_row = (cy_q >= yend_q) || (cy_nxt >= yend_q);
	end

	// grid-relative edges: left/top floor, right/bottom ceil
	assign div_start = (state_q == ST_SETUP) && is_query;
	always_comb begin
		dreq[LANE_LEFT]   = '{start: div_start, ceil_mode: 1'b0,
			dividend: x_ext - ox_ext, divisor: tile_div};
		dreq[LANE_RIGHT]  = '{start: div_start, ceil_mode: 1'b1,
			dividend: x_ext - ox_ext + w_ext, divisor: tile_div};
		dreq[LANE_TOP]    = '{start: div_start, ceil_mode: 1'b0,
			dividend: y_ext - oy_ext, divisor: tile_div};
		dreq[LANE_BOTTOM] = '{start: div_start, ceil_mode: 1'b1,
			dividend: y_ext - oy_ext + h_ext, divisor: tile_div};
	end

	for (genvar l = 0; l < NLANE; l++) begin : g_div
		rtgc_div u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.req    (dreq[l]),
			.rsp    (drsp[l])
		);
	end

	assign div_done = drsp[LANE_LEFT].done && drsp[LANE_RIGHT].done &&
		drsp[LANE_TOP].done && drsp[LANE_BOTTOM].done;

	always_comb begin
		for (int c = 0; c < MAX_COLUMNS; c++) begin
			mask_c[c] = (CNTW'(c) >= lo_q) && (CNTW'(c) < hi_q);
		end
		row_data_c = rok_s1 ? rd_data : '0;
		wr_data    = item_q.cell_value ? (row_data_c | mask_c) : (row_data_c & ~mask_c);
		wr_en      = rd_vld_s1 && wr_mode;
		rd_en      = (state_q == ST_SCAN) && (cy_q < yend_q);
		rd_addr    = cy_q[RAW-1:0];
	end

	rtgc_ram #(
		.WIDTH (MAX_COLUMNS),
		.DEPTH (MAX_ROWS)
	) u_map (
		.clk   (clk),
		.we    (wr_en),
		.waddr (row_s1),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_size_q    <= TILE_SIZE_RST;
			grid_columns_q <= GRID_COLUMNS_RST;
			grid_rows_q    <= GRID_ROWS_RST;
			origin_x_q     <= '0;
			origin_y_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TILE_SIZE:    tile_size_q    <= cfg_data[TSW-1:0];
				CFG_GRID_COLUMNS: grid_columns_q <= cfg_data[GDW-1:0];
				CFG_GRID_ROWS:    grid_rows_q    <= cfg_data[GDW-1:0];
				CFG_ORIGIN_X:     origin_x_q     <= $signed(cfg_data[CRDW-1:0]);
				CFG_ORIGIN_Y:     origin_y_q     <= $signed(cfg_data[CRDW-1:0]);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_q <= in_data;
		end
		row_s1 <= rd_addr;
		rok_s1 <= row_vld_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lo_q        <= '0;
			hi_q        <= '0;
			cy_q        <= '0;
			yend_q      <= '0;
			row_vld_q   <= '0;
			res_hit_q   <= 1'b0;
			res_bad_q   <= 1'b0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (wr_en) begin
				row_vld_q[row_s1] <= 1'b1;
			end
			if (rd_vld_s1 && !wr_mode && ((row_data_c & mask_c) != '0)) begin
				res_hit_q <= 1'b1;
			end
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					res_hit_q <= 1'b0;
					res_bad_q <= cell_bad &&
						((item_q.op == OP_WRITE_CELL) || (item_q.op == OP_READ_CELL));
					unique case (item_q.op) inside
						OP_WRITE_CELL, OP_READ_CELL: begin
							if (cell_bad) begin
								state_q   <= ST_DONE;
							end else begin
								lo_q    <= cell_col;
								hi_q    <= cell_col + CNTW'(1);
								cy_q    <= cell_row;
								yend_q  <= cell_row + RCNTW'(1);
								state_q <= ST_SCAN;
							end
						end
						OP_FILL_REGION: begin
							lo_q    <= col_lo_c[CNTW-1:0];
							hi_q    <= col_hi_c[CNTW-1:0];
							cy_q    <= row_lo_c[RCNTW-1:0];
							yend_q  <= row_hi_c[RCNTW-1:0];
							state_q <= ST_SCAN;
						end
						OP_QUERY_RECT: begin
							state_q <= ST_DIV;
						end
					endcase
				end
				ST_DIV: begin
					if (div_done) begin
						lo_q    <= col_lo_c[CNTW-1:0];
						hi_q    <= col_hi_c[CNTW-1:0];
						cy_q    <= row_lo_c[RCNTW-1:0];
						yend_q  <= row_hi_c[RCNTW-1:0];
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cy_q < yend_q) begin
						cy_q <= cy_nxt;
					end
					if (last_row) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q      <= 1'b1;
						out_q.hit        <= res_hit_q;
						out_q.bad_access <= res_bad_q;
						state_q          <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/rtgc_chk.sv]
`default_nettype none
`include "assert_macros.svh"

module rtgc_chk import rtgc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	`RTGC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result changed while stalled")
	`RTGC_ASSERT_NEVER(a_hit_and_bad, out_valid && out_data.hit && out_data.bad_access, "hit on a refused access")
	`RTGC_ASSERT(a_one_in_flight, in_valid && !in_stall |=> in_stall, "second transaction taken while busy")
	`RTGC_ASSERT(a_no_instant_result, in_valid && !in_stall |=> !$rose(out_valid), "result appeared one cycle after accept")

endmodule

bind rect_vs_tile_grid_collision rtgc_chk u_rtgc_chk (.*);

`default_nettype wire
